>>> rtl/debounced_countdown_timer_macros.svh
// Assertion macros for the countdown timer block.
// Uses the clk_i and rst_ni names of the module that includes this file.
`ifndef DEBOUNCED_COUNTDOWN_TIMER_MACROS_SVH
`define DEBOUNCED_COUNTDOWN_TIMER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked only out of reset.
`define DCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every edge, reset included.
`define DCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DCT_ASSERT(lbl, prop, msg)
`define DCT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/dct_pkg.sv
// Shared constants and types of the debounced countdown timer.
// No dependencies; used by every other file of the block but the assertion macros.
package dct_pkg;

  localparam logic [6:0] MINUTE_LIMIT = 7'd99;
  localparam logic [5:0] SECOND_LAST  = 6'd59;

  localparam logic [1:0] MODE_SETTING  = 2'd0;
  localparam logic [1:0] MODE_COUNTING = 2'd1;
  localparam logic [1:0] MODE_PAUSED   = 2'd2;

  localparam logic [2:0] KEY_MINUTE      = 3'b001;
  localparam logic [2:0] KEY_START       = 3'b010;
  localparam logic [2:0] KEY_SECOND      = 3'b100;
  localparam logic [2:0] LEVELS_RELEASED = 3'b111;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS    = 2'd1;

  localparam logic [3:0]  DEBOUNCE_RESET = 4'd7;
  localparam logic [9:0]  TICKS_RESET    = 10'd100;
  localparam logic [10:0] PRESCALE_MAX   = 11'h7FF;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] minutes;
    logic [5:0] seconds;
    logic [2:0] pressed;
    logic       expired;
  } result_t;

endpackage

>>> rtl/dct_if.sv
// Handshake channels of the countdown timer: input ticks, results, config writes.
// Depends on dct_pkg for the config widths.
interface dct_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] switch_levels;
  modport source (output valid, output switch_levels, input ready);
  modport sink (input valid, input switch_levels, output ready);
endinterface

interface dct_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [6:0] minutes;
  logic [5:0] seconds;
  logic [2:0] pressed;
  logic       expired;
  modport source (output valid, output mode, output minutes, output seconds,
                  output pressed, output expired, input ready);
  modport sink (input valid, input mode, input minutes, input seconds,
                input pressed, input expired, output ready);
endinterface

interface dct_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dct_pkg::CFG_IDX_W-1:0]   index;
  logic [dct_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/debounced_countdown_timer.sv
// Path: an accepted tick is held in the input register, then its result in the output register.
// Throughput: one tick per cycle; the input register holds one tick while a
// result waits, set by the state update between the two registers.
// Reset: asynchronous, active low; state returns to setting mode, time zero,
// switches released, registers to 7 matches and 100 ticks per second.
`include "debounced_countdown_timer_macros.svh"

module debounced_countdown_timer (
  input  logic      clk_i,
  input  logic      rst_ni,
  dct_in_if.sink    in_i,
  dct_out_if.source out_o,
  dct_cfg_if.sink   cfg_i
);

  logic [3:0]       debounce_matches_q;
  logic [9:0]       ticks_per_second_q;
  logic             s1_valid_q, s1_valid_d;
  logic [2:0]       s1_levels_q;
  logic             out_valid_q, out_valid_d;
  dct_pkg::result_t out_q, result;
  logic             in_acc, advance;
  logic [2:0]       pressed;
  logic             time_ok, expired_ok, both_full;

  assign advance     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || advance;
  assign in_acc      = in_i.valid && in_i.ready;
  assign s1_valid_d  = in_acc || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_o.ready);
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_matches_q <= dct_pkg::DEBOUNCE_RESET;
      ticks_per_second_q <= dct_pkg::TICKS_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == dct_pkg::CFG_DEBOUNCE) begin
        debounce_matches_q <= cfg_i.data[3:0];
      end else if (cfg_i.index == dct_pkg::CFG_TICKS) begin
        ticks_per_second_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload: hold unless a beat moves
  always_ff @(posedge clk_i) begin
    if (in_acc) s1_levels_q <= in_i.switch_levels;
    if (advance) out_q <= result;
  end

  dct_debounce u_debounce (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .en_i               (advance),
    .levels_i           (s1_levels_q),
    .debounce_matches_i (debounce_matches_q),
    .pressed_o          (pressed)
  );

  dct_timer u_timer (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .en_i               (advance),
    .pressed_i          (pressed),
    .ticks_per_second_i (ticks_per_second_q),
    .result_o           (result)
  );

  assign out_o.valid   = out_valid_q;
  assign out_o.mode    = out_q.mode;
  assign out_o.minutes = out_q.minutes;
  assign out_o.seconds = out_q.seconds;
  assign out_o.pressed = out_q.pressed;
  assign out_o.expired = out_q.expired;

  assign time_ok    = (out_q.minutes <= dct_pkg::MINUTE_LIMIT) &&
                      (out_q.seconds <= dct_pkg::SECOND_LAST);
  assign expired_ok = !out_q.expired || (out_q.mode == dct_pkg::MODE_SETTING);
  assign both_full  = s1_valid_q && out_valid_q && !out_o.ready;

  `DCT_ASSERT(a_time_range, out_valid_q |-> time_ok, "time out of range")
  `DCT_ASSERT(a_expired_mode, out_valid_q |-> expired_ok, "expiry outside setting mode")
  `DCT_ASSERT_ALWAYS(a_full_stall, both_full |-> !in_i.ready, "tick taken with both stages full")

endmodule

>>> rtl/dct_debounce.sv
// Switch debouncer: accepts a level pattern after enough equal samples
// and reports high-to-low edges of the accepted pattern. Uses dct_pkg.
module dct_debounce (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [2:0] levels_i,
  input  logic [3:0] debounce_matches_i,
  output logic [2:0] pressed_o
);

  logic [2:0] last_q, last_d;
  logic [3:0] match_q, match_d;
  logic [2:0] stable_q, stable_d;
  logic [3:0] match_inc;

  always_comb begin
    last_d    = last_q;
    match_d   = match_q;
    stable_d  = stable_q;
    match_inc = match_q + 4'd1;
    if (levels_i != last_q) begin
      match_d = '0;
      last_d  = levels_i;
    end else if (match_inc >= debounce_matches_i) begin
      match_d  = '0;
      stable_d = levels_i;
    end else begin
      match_d = match_inc;
    end
  end

  // edge towards pressed (active low)
  assign pressed_o = (stable_d ^ stable_q) & ~stable_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= dct_pkg::LEVELS_RELEASED;
      match_q  <= '0;
      stable_q <= dct_pkg::LEVELS_RELEASED;
    end else if (en_i) begin
      last_q   <= last_d;
      match_q  <= match_d;
      stable_q <= stable_d;
    end
  end

endmodule

>>> rtl/dct_timer.sv
// Timer core: mode control, time setting and the prescaled countdown.
// Takes the debounced press edges; uses dct_pkg for codes and result_t.
module dct_timer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [2:0]       pressed_i,
  input  logic [9:0]       ticks_per_second_i,
  output dct_pkg::result_t result_o
);

  logic [1:0]  mode_q, mode_d, mode_k;
  logic [6:0]  min_q, min_d, min_k;
  logic [5:0]  sec_q, sec_d, sec_k;
  logic [10:0] pre_q, pre_d, pre_inc;
  logic        expired;

  // key actions
  always_comb begin
    mode_k = mode_q;
    min_k  = min_q;
    sec_k  = sec_q;
    unique case (pressed_i)
      dct_pkg::KEY_SECOND: begin
        if (mode_q == dct_pkg::MODE_SETTING) begin
          if (sec_q < dct_pkg::SECOND_LAST) begin
            sec_k = sec_q + 6'd1;
          end else if (min_q < dct_pkg::MINUTE_LIMIT) begin
            sec_k = '0;
            min_k = min_q + 7'd1;
          end
        end
      end
      dct_pkg::KEY_MINUTE: begin
        if (mode_q == dct_pkg::MODE_SETTING) begin
          if (min_q < dct_pkg::MINUTE_LIMIT) min_k = min_q + 7'd1;
        end else if (mode_q == dct_pkg::MODE_PAUSED) begin
          min_k  = '0;
          sec_k  = '0;
          mode_k = dct_pkg::MODE_SETTING;
        end
      end
      dct_pkg::KEY_START: begin
        if (mode_q == dct_pkg::MODE_COUNTING) begin
          mode_k = dct_pkg::MODE_PAUSED;
        end else if (min_q != '0 || sec_q != '0) begin
          mode_k = dct_pkg::MODE_COUNTING;
        end
      end
      default: ;
    endcase
  end

  // prescaler and countdown
  always_comb begin
    mode_d  = mode_k;
    min_d   = min_k;
    sec_d   = sec_k;
    pre_d   = pre_q;
    expired = 1'b0;
    pre_inc = (pre_q != dct_pkg::PRESCALE_MAX) ? pre_q + 11'd1 : pre_q;
    if (mode_k == dct_pkg::MODE_COUNTING) begin
      pre_d = pre_inc;
      if (pre_inc >= {1'b0, ticks_per_second_i}) begin
        if (min_k == '0 && sec_k == '0) begin
          // the prescaler is not cleared on expiry
          mode_d  = dct_pkg::MODE_SETTING;
          expired = 1'b1;
        end else begin
          if (sec_k == '0) begin
            sec_d = dct_pkg::SECOND_LAST;
            min_d = min_k - 7'd1;
          end else begin
            sec_d = sec_k - 6'd1;
          end
          pre_d = '0;
        end
      end
    end
  end

  assign result_o.mode    = mode_d;
  assign result_o.minutes = min_d;
  assign result_o.seconds = sec_d;
  assign result_o.pressed = pressed_i;
  assign result_o.expired = expired;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= dct_pkg::MODE_SETTING;
      min_q  <= '0;
      sec_q  <= '0;
      pre_q  <= '0;
    end else if (en_i) begin
      mode_q <= mode_d;
      min_q  <= min_d;
      sec_q  <= sec_d;
      pre_q  <= pre_d;
    end
  end

endmodule

>>> tb/sv/dct_readout_checker.sv
// Readout scoreboard for the debounced countdown timer: models debounce, keys and countdown.
// Depends on dct_pkg and the channel interfaces; watches tick, readout and register beats.
module dct_readout_checker
  import dct_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  dct_in_if           tick_i,
  dct_out_if          readout_i,
  dct_cfg_if          reg_i,
  output int unsigned mismatches_o,
  output int unsigned results_due_o
);

  logic [3:0]  debounce_cfg;
  logic [9:0]  ticks_cfg;
  logic [2:0]  last_raw;
  logic [3:0]  match_cnt;
  logic [2:0]  settled_levels;
  logic [1:0]  timer_mode;
  logic [6:0]  min_cnt;
  logic [5:0]  sec_cnt;
  logic [10:0] prescale_cnt;
  result_t     pending_readouts [$];

  // Advance the timer by one sampling tick and return the readout it should produce.
  function automatic result_t tick_timer(input logic [2:0] raw);
    logic [2:0] prev_levels;
    logic [2:0] edges;
    logic       ran_out;
    result_t    r;
    prev_levels = settled_levels;
    ran_out     = 1'b0;
    if (raw != last_raw) begin
      match_cnt = '0;
      last_raw  = raw;
    end else begin
      match_cnt = match_cnt + 4'd1;
      if (match_cnt >= debounce_cfg) begin
        match_cnt      = '0;
        settled_levels = raw;
      end
    end
    edges = (settled_levels ^ prev_levels) & ~settled_levels;

    // only a lone press acts; simultaneous presses are shown but ignored
    case (edges)
      KEY_SECOND: begin
        if (timer_mode == MODE_SETTING) begin
          if (sec_cnt < SECOND_LAST) begin
            sec_cnt = sec_cnt + 6'd1;
          end else if (min_cnt < MINUTE_LIMIT) begin
            sec_cnt = '0;
            min_cnt = min_cnt + 7'd1;
          end
        end
      end
      KEY_MINUTE: begin
        if (timer_mode == MODE_SETTING) begin
          if (min_cnt < MINUTE_LIMIT) min_cnt = min_cnt + 7'd1;
        end else if (timer_mode == MODE_PAUSED) begin
          min_cnt    = '0;
          sec_cnt    = '0;
          timer_mode = MODE_SETTING;
        end
      end
      KEY_START: begin
        if (timer_mode == MODE_COUNTING) begin
          timer_mode = MODE_PAUSED;
        end else if (min_cnt != '0 || sec_cnt != '0) begin
          timer_mode = MODE_COUNTING;
        end
      end
      default: ;
    endcase

    if (timer_mode == MODE_COUNTING) begin
      if (prescale_cnt != PRESCALE_MAX) prescale_cnt = prescale_cnt + 11'd1;
      if (prescale_cnt >= {1'b0, ticks_cfg}) begin
        // at zero the prescaler keeps its count
        if (min_cnt == '0 && sec_cnt == '0) begin
          timer_mode = MODE_SETTING;
          ran_out    = 1'b1;
        end else begin
          if (sec_cnt == '0) begin
            sec_cnt = SECOND_LAST;
            min_cnt = min_cnt - 7'd1;
          end else begin
            sec_cnt = sec_cnt - 6'd1;
          end
          prescale_cnt = '0;
        end
      end
    end

    r.mode    = timer_mode;
    r.minutes = min_cnt;
    r.seconds = sec_cnt;
    r.pressed = edges;
    r.expired = ran_out;
    return r;
  endfunction

  function automatic int field_diff(input string field, input logic [6:0] want,
                                    input logic [6:0] got);
    if (want === got) return 0;
    $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t seen;
    result_t want;
    int      wrong;
    if (!rst_ni) begin
      debounce_cfg   = DEBOUNCE_RESET;
      ticks_cfg      = TICKS_RESET;
      last_raw       = LEVELS_RELEASED;
      match_cnt      = '0;
      settled_levels = LEVELS_RELEASED;
      timer_mode     = MODE_SETTING;
      min_cnt        = '0;
      sec_cnt        = '0;
      prescale_cnt   = '0;
      pending_readouts.delete();
      mismatches_o   = 0;
      results_due_o  = 0;
    end else begin
      // retire the readout beat before queueing this edge's tick
      if (readout_i.valid && readout_i.ready) begin
        seen.mode    = readout_i.mode;
        seen.minutes = readout_i.minutes;
        seen.seconds = readout_i.seconds;
        seen.pressed = readout_i.pressed;
        seen.expired = readout_i.expired;
        if (pending_readouts.size() == 0) begin
          $display("%0t: expected no readout, got mode %0d time %0d:%0d pressed %0d expired %0d",
                   $time, seen.mode, seen.minutes, seen.seconds, seen.pressed, seen.expired);
          mismatches_o++;
        end else begin
          want  = pending_readouts.pop_front();
          wrong = field_diff("mode", want.mode, seen.mode)
                + field_diff("minutes", want.minutes, seen.minutes)
                + field_diff("seconds", want.seconds, seen.seconds)
                + field_diff("pressed", want.pressed, seen.pressed)
                + field_diff("expired", want.expired, seen.expired);
          if (wrong != 0) mismatches_o++;
        end
      end
      if (reg_i.valid && reg_i.ready) begin
        case (reg_i.index)
          CFG_DEBOUNCE: debounce_cfg = reg_i.data[3:0];
          CFG_TICKS:    ticks_cfg    = reg_i.data;
          default: ;
        endcase
      end
      if (tick_i.valid && tick_i.ready) begin
        pending_readouts.push_back(tick_timer(tick_i.switch_levels));
      end
      results_due_o = pending_readouts.size();
    end
  end

endmodule

>>> tb/sv/debounced_countdown_timer_tb.sv
// Top of the countdown timer bench: clock, reset, key-press stimulus and the verdict.
// Depends on dct_pkg, the channel interfaces, the block and dct_readout_checker.
module debounced_countdown_timer_tb;
  import dct_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned PHASE_TICKS    = 60;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned gap_pct      = 0;
  int unsigned stall_pct    = 0;
  int unsigned debounce_set = 0;
  int unsigned ticks_sent   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned mismatches;
  int unsigned results_due;

  dct_in_if  tick_ch ();
  dct_out_if readout_ch ();
  dct_cfg_if reg_ch ();

  debounced_countdown_timer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_ch),
    .out_o  (readout_ch),
    .cfg_i  (reg_ch)
  );

  dct_readout_checker readout_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (tick_ch),
    .readout_i     (readout_ch),
    .reg_i         (reg_ch),
    .mismatches_o  (mismatches),
    .results_due_o (results_due)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    readout_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      readout_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((tick_ch.valid && tick_ch.ready) || (readout_ch.valid && readout_ch.ready) ||
        (reg_ch.valid && reg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_tick(input logic [2:0] levels);
    while ($urandom_range(0, 99) < gap_pct) begin
      tick_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    tick_ch.valid         <= 1'b1;
    tick_ch.switch_levels <= levels;
    do begin
      @(posedge clk_i);
    end while (!tick_ch.ready);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic hold_levels(input logic [2:0] levels, input int unsigned count);
    repeat (count) send_tick(levels);
  endtask

  task automatic press(input logic [2:0] levels, input int unsigned hold);
    hold_levels(levels, hold);
    hold_levels(LEVELS_RELEASED, hold);
  endtask

  // Hold off ticks until every readout is back.
  task automatic drain();
    tick_ch.valid <= 1'b0;
    do begin
      @(negedge clk_i);
    end while (results_due != 0);
  endtask

  // Leaves valid high; the caller drops it after the last beat.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] word);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data  <= word;
    do begin
      @(posedge clk_i);
    end while (!reg_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] debounce_word,
                          input logic [CFG_DATA_W-1:0] ticks_word,
                          input int unsigned gap, input int unsigned stall);
    drain();
    write_reg(CFG_DEBOUNCE, debounce_word);
    write_reg(CFG_TICKS, ticks_word);
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    reg_ch.valid <= 1'b0;
    debounce_set = debounce_word[3:0];
    gap_pct      = gap;
    stall_pct    = stall;
  endtask

  // Mostly clean presses long enough to settle, plus idle runs, glitches and drains.
  task automatic run_random(input int unsigned budget);
    int unsigned start_count;
    int unsigned pick;
    int unsigned hold;
    start_count = ticks_sent;
    while (ticks_sent - start_count < budget) begin
      pick = $urandom_range(0, 99);
      hold = debounce_set + 1 + $urandom_range(1, 2);
      if (pick < 30) begin
        press(LEVELS_RELEASED ^ KEY_SECOND, hold);
      end else if (pick < 45) begin
        press(LEVELS_RELEASED ^ KEY_MINUTE, hold);
      end else if (pick < 65) begin
        press(LEVELS_RELEASED ^ KEY_START, hold);
      end else if (pick < 71) begin
        // two or three keys together
        press(3'(4'd1 << $urandom_range(0, 3)), hold);
      end else if (pick < 85) begin
        hold_levels(LEVELS_RELEASED, $urandom_range(1, 40));
      end else if (pick < 97) begin
        repeat ($urandom_range(1, 6)) begin
          hold_levels(3'($urandom_range(0, 7)), $urandom_range(1, debounce_set + 1));
        end
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    rst_ni                = 1'b0;
    tick_ch.valid         = 1'b0;
    tick_ch.switch_levels = LEVELS_RELEASED;
    reg_ch.valid          = 1'b0;
    reg_ch.index          = CFG_DEBOUNCE;
    reg_ch.data           = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Zero registers: settle on the first repeat, a second off every counting tick.
    set_regs(10'd0, 10'd0, 0, 0);
    press(LEVELS_RELEASED ^ KEY_START, 2);
    press(~LEVELS_RELEASED, 2);
    press(LEVELS_RELEASED ^ KEY_SECOND, 2);
    press(LEVELS_RELEASED ^ KEY_START, 2);
    press(LEVELS_RELEASED ^ KEY_MINUTE, 2);
    press(LEVELS_RELEASED ^ KEY_START, 2);
    press(LEVELS_RELEASED ^ KEY_MINUTE, 2);
    press(LEVELS_RELEASED ^ KEY_START, 2);
    press(LEVELS_RELEASED ^ KEY_MINUTE, 2);

    // Wind the set time through the seconds carry up to the limit, then clear it.
    set_regs(10'd0, 10'd1, 32, 32);
    repeat (60) press(LEVELS_RELEASED ^ KEY_SECOND, 2);
    repeat (99) press(LEVELS_RELEASED ^ KEY_MINUTE, 2);
    repeat (60) press(LEVELS_RELEASED ^ KEY_SECOND, 2);
    press(LEVELS_RELEASED ^ KEY_START, 2);
    press(LEVELS_RELEASED ^ KEY_START, 2);
    press(LEVELS_RELEASED ^ KEY_MINUTE, 2);

    set_regs(10'd1, 10'd3, 0, 0);
    run_random(PHASE_TICKS);
    set_regs(10'd15, 10'd1000, 86, 0);
    run_random(PHASE_TICKS);
    set_regs(10'd2, 10'd1, 0, 86);
    run_random(PHASE_TICKS);
    set_regs(10'd7, 10'd100, 32, 32);
    run_random(PHASE_TICKS);
    set_regs(10'd0, 10'd2, 86, 0);
    run_random(PHASE_TICKS);
    set_regs(10'd3, 10'd1023, 0, 0);
    run_random(PHASE_TICKS);
    // upper data bits above the debounce field must be dropped
    set_regs(10'h3F1, 10'd5, 0, 86);
    run_random(PHASE_TICKS);

    drain();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && results_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/dct_pkg.sv
rtl/dct_if.sv
rtl/dct_debounce.sv
rtl/dct_timer.sv
rtl/debounced_countdown_timer.sv
tb/sv/dct_readout_checker.sv
tb/sv/debounced_countdown_timer_tb.sv
